/* design/bvc_pkg.sv */
// ----------------------------------------------------------------------------
// bvc_pkg
// Shared types, constants and helpers for the border viewport compositor.
// ----------------------------------------------------------------------------
`default_nettype none

package bvc_pkg;

  localparam int CoordW = 12;            // canvas / source coordinate width
  localparam int DimW   = 13;            // config register width
  localparam int PixW   = 32;            // ARGB word
  localparam int ProdW  = 2 * DimW;      // offset times source size
  localparam int DivSteps = DimW;        // quotient bits per axis
  localparam int CfgIdxW = 3;

  localparam logic [7:0] AlphaFull = 8'hFF;

  // Register indexes on the config channel
  typedef enum logic [CfgIdxW-1:0] {
    REG_UNDERLAY = 3'd0,
    REG_VP_X     = 3'd1,
    REG_VP_Y     = 3'd2,
    REG_VP_W     = 3'd3,
    REG_VP_H     = 3'd4,
    REG_SRC_W    = 3'd5,
    REG_SRC_H    = 3'd6
  } cfg_idx_e;

  // Live configuration, top level to front end
  typedef struct packed {
    logic            underlay;
    logic [DimW-1:0] vp_x;
    logic [DimW-1:0] vp_y;
    logic [DimW-1:0] vp_w;
    logic [DimW-1:0] vp_h;
    logic [DimW-1:0] src_w;
    logic [DimW-1:0] src_h;
  } cfg_t;

  // One queued item: finished pixel plus the two pending divisions
  typedef struct packed {
    logic             in_vp;
    logic [PixW-1:0]  pix;
    logic [ProdW-1:0] prod_x;
    logic [ProdW-1:0] prod_y;
    logic [DimW-1:0]  div_x;
    logic [DimW-1:0]  div_y;
  } q_entry_t;

  // x / 255 for x up to 255*255
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
    return t[15:8];
  endfunction

endpackage

`default_nettype wire

/* design/bvc_if.sv */
// ----------------------------------------------------------------------------
// bvc_if
// Channel interfaces: pixel in, result out, configuration writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface bvc_pix_if;
  logic        valid;
  logic        ready;
  logic [11:0] canvas_x;
  logic [11:0] canvas_y;
  logic [31:0] border_pixel;
  logic [31:0] game_pixel;
  modport source (output valid, canvas_x, canvas_y, border_pixel, game_pixel, input ready);
  modport sink   (input valid, canvas_x, canvas_y, border_pixel, game_pixel, output ready);
endinterface

interface bvc_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_pixel;
  logic        in_viewport;
  logic [11:0] source_x;
  logic [11:0] source_y;
  modport source (output valid, out_pixel, in_viewport, source_x, source_y, input ready);
  modport sink   (input valid, out_pixel, in_viewport, source_x, source_y, output ready);
endinterface

interface bvc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [12:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* design/bvc_front.sv */
// ----------------------------------------------------------------------------
// bvc_front
// Viewport test, offset products and blend channel sums; two stages.
// ----------------------------------------------------------------------------
`default_nettype none

module bvc_front import bvc_pkg::*; #(
  parameter int MAX_DIMENSION = 4096
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire cfg_t     cfg_i,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire logic [CoordW-1:0] canvas_x_i,
  input  wire logic [CoordW-1:0] canvas_y_i,
  input  wire logic [PixW-1:0]   border_i,
  input  wire logic [PixW-1:0]   game_i,
  output logic          push_o,
  input  wire logic     push_ok_i,
  output q_entry_t      entry_o
);

  function automatic logic [DimW-1:0] sat_dim(input logic [DimW-1:0] v);
    return (32'(v) > MAX_DIMENSION) ? DimW'(MAX_DIMENSION) : v;
  endfunction

  logic en;

  // stage 1: classification
  logic [DimW:0]   off_x, off_y;
  logic [DimW-1:0] vsx, vsy, ssx, ssy;
  logic            in_x, in_y;
  logic            s1_v_q, s1_in_q, s1_mode_q;
  logic [DimW-1:0] s1_offx_q, s1_offy_q, s1_ssx_q, s1_ssy_q, s1_vsx_q, s1_vsy_q;
  logic [PixW-1:0] s1_border_q, s1_under_q;

  assign off_x = {2'b00, canvas_x_i} - {cfg_i.vp_x[DimW-1], cfg_i.vp_x};
  assign off_y = {2'b00, canvas_y_i} - {cfg_i.vp_y[DimW-1], cfg_i.vp_y};
  assign vsx = sat_dim(cfg_i.vp_w);
  assign vsy = sat_dim(cfg_i.vp_h);
  assign ssx = sat_dim(cfg_i.src_w);
  assign ssy = sat_dim(cfg_i.src_h);
  assign in_x = (vsx != '0) && !off_x[DimW] && (off_x[DimW-1:0] < vsx);
  assign in_y = (vsy != '0) && !off_y[DimW] && (off_y[DimW-1:0] < vsy);

  // stage 2: products
  logic            s2_v_q, s2_in_q, s2_mode_q;
  logic [ProdW-1:0] s2_px_q, s2_py_q;
  logic [DimW-1:0] s2_vsx_q, s2_vsy_q;
  logic [PixW-1:0] s2_border_q, s2_under_q;
  logic [15:0]     s2_sum_q [3];
  logic [15:0]     s2_asum_q;
  logic [7:0]      a1, inv1;

  assign a1   = s1_border_q[31:24];
  assign inv1 = AlphaFull - a1;

  assign en         = !s2_v_q || push_ok_i;
  assign in_ready_o = en;
  assign push_o     = s2_v_q && push_ok_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= in_valid_i;
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_in_q     <= in_x && in_y;
      s1_mode_q   <= cfg_i.underlay;
      s1_offx_q   <= off_x[DimW-1:0];
      s1_offy_q   <= off_y[DimW-1:0];
      s1_ssx_q    <= ssx;
      s1_ssy_q    <= ssy;
      s1_vsx_q    <= vsx;
      s1_vsy_q    <= vsy;
      s1_border_q <= border_i;
      s1_under_q  <= (in_x && in_y) ? game_i : '0;

      s2_in_q     <= s1_in_q;
      s2_mode_q   <= s1_mode_q;
      s2_px_q     <= s1_offx_q * s1_ssx_q;
      s2_py_q     <= s1_offy_q * s1_ssy_q;
      s2_vsx_q    <= s1_vsx_q;
      s2_vsy_q    <= s1_vsy_q;
      s2_border_q <= s1_border_q;
      s2_under_q  <= s1_under_q;
      for (int c = 0; c < 3; c++) begin
        s2_sum_q[c] <= 16'(s1_border_q[8*c +: 8] * a1) + 16'(s1_under_q[8*c +: 8] * inv1);
      end
      s2_asum_q   <= 16'(s1_under_q[31:24] * inv1);
    end
  end

  // blend finish and queue entry
  logic [7:0]      a2;
  logic [PixW-1:0] mix;
  assign a2 = s2_border_q[31:24];

  always_comb begin
    mix[31:24] = a2 + div255(s2_asum_q);
    mix[23:16] = div255(s2_sum_q[2]);
    mix[15:8]  = div255(s2_sum_q[1]);
    mix[7:0]   = div255(s2_sum_q[0]);
  end

  always_comb begin
    entry_o.in_vp  = s2_in_q;
    entry_o.prod_x = s2_px_q;
    entry_o.prod_y = s2_py_q;
    entry_o.div_x  = s2_vsx_q;
    entry_o.div_y  = s2_vsy_q;
    if (s2_mode_q)
      entry_o.pix = s2_in_q ? s2_under_q : s2_border_q;
    else if (a2 == AlphaFull)
      entry_o.pix = s2_border_q;
    else if (a2 == 8'd0)
      entry_o.pix = s2_under_q;
    else
      entry_o.pix = mix;
  end

endmodule

`default_nettype wire

/* design/bvc_queue.sv */
// ----------------------------------------------------------------------------
// bvc_queue
// Two-entry FIFO between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module bvc_queue import bvc_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire q_entry_t wdata_i,
  output logic          push_ok_o,
  input  wire logic     pop_i,
  output logic          nonempty_o,
  output q_entry_t      rdata_o
);

  q_entry_t   mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign nonempty_o = (cnt_q != 2'd0);
  assign push_ok_o  = (cnt_q != 2'd2) || pop_i;
  assign rdata_o    = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= wdata_i;
  end

endmodule

`default_nettype wire

/* design/bvc_back.sv */
// ----------------------------------------------------------------------------
// bvc_back
// Restoring divider pipeline, one quotient bit per stage on each axis,
// followed by the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bvc_back import bvc_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     nonempty_i,
  input  wire q_entry_t head_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output logic [PixW-1:0]   out_pixel_o,
  output logic              in_viewport_o,
  output logic [CoordW-1:0] source_x_o,
  output logic [CoordW-1:0] source_y_o
);

  // one divide step: shift in a dividend bit, subtract if it fits
  function automatic logic [DimW:0] div_step(input logic [DimW-1:0] r, input logic b,
                                             input logic [DimW-1:0] d);
    logic [DimW:0] t;
    t = {r, b};
    if (t >= {1'b0, d}) return {t[DimW-1:0] - d, 1'b1};
    return {t[DimW-1:0], 1'b0};
  endfunction

  logic en;
  logic out_v_q;

  // index 0 is the queue head; index k+1 is stage k
  logic            v    [DivSteps+1];
  logic            ins  [DivSteps+1];
  logic [PixW-1:0] pix  [DivSteps+1];
  logic [DimW-1:0] rx   [DivSteps+1], ry [DivSteps+1];
  logic [DimW-1:0] lx   [DivSteps+1], ly [DivSteps+1];
  logic [DimW-1:0] qx   [DivSteps+1], qy [DivSteps+1];
  logic [DimW-1:0] dx   [DivSteps+1], dy [DivSteps+1];

  assign en    = !out_v_q || out_ready_i;
  assign pop_o = en && nonempty_i;

  assign v[0]   = nonempty_i;
  assign ins[0] = head_i.in_vp;
  assign pix[0] = head_i.pix;
  assign rx[0]  = head_i.prod_x[ProdW-1:DimW];
  assign ry[0]  = head_i.prod_y[ProdW-1:DimW];
  assign lx[0]  = head_i.prod_x[DimW-1:0];
  assign ly[0]  = head_i.prod_y[DimW-1:0];
  assign qx[0]  = '0;
  assign qy[0]  = '0;
  assign dx[0]  = head_i.div_x;
  assign dy[0]  = head_i.div_y;

  for (genvar k = 0; k < DivSteps; k++) begin : g_stage
    logic [DimW:0] sx, sy;
    assign sx = div_step(rx[k], lx[k][DimW-1], dx[k]);
    assign sy = div_step(ry[k], ly[k][DimW-1], dy[k]);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v[k+1] <= 1'b0;
      end else if (en) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        ins[k+1] <= ins[k];
        pix[k+1] <= pix[k];
        rx[k+1]  <= sx[DimW:1];
        ry[k+1]  <= sy[DimW:1];
        lx[k+1]  <= {lx[k][DimW-2:0], 1'b0};
        ly[k+1]  <= {ly[k][DimW-2:0], 1'b0};
        qx[k+1]  <= {qx[k][DimW-2:0], sx[0]};
        qy[k+1]  <= {qy[k][DimW-2:0], sy[0]};
        dx[k+1]  <= dx[k];
        dy[k+1]  <= dy[k];
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= v[DivSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_pixel_o   <= pix[DivSteps];
      in_viewport_o <= ins[DivSteps];
      source_x_o    <= ins[DivSteps] ? qx[DivSteps][CoordW-1:0] : '0;
      source_y_o    <= ins[DivSteps] ? qy[DivSteps][CoordW-1:0] : '0;
    end
  end

  assign out_valid_o = out_v_q;

endmodule

`default_nettype wire

/* design/border_viewport_compositor.sv */
// ----------------------------------------------------------------------------
// border_viewport_compositor
// Composites a border canvas with a game frame scaled into a viewport.
//
// Channels: pix_i takes one canvas pixel per beat (coordinates, border word
// and the game word at the source position); res_o gives one composited beat
// per input beat, in order. cfg_i writes the seven registers (always ready).
// Path from an accepted input beat to its result beat: two front stages,
// the queue, 13 divider stages and the output register.
// The divider pipeline retires one quotient bit per stage per axis.
// Throughput: one beat per clock while the receiver keeps up.
// Reset: registers take their defaults (viewport 256x240 at origin, source
// 256x240, overlay mode); all pipelines empty.
// Receiver stall: the back end freezes; the two-entry queue absorbs the front
// end's items, then pix_i.ready drops until the back end moves again.
// ----------------------------------------------------------------------------
`default_nettype none

module border_viewport_compositor import bvc_pkg::*; #(
  parameter int MAX_DIMENSION = 4096
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  bvc_cfg_if.sink     cfg_i,
  bvc_pix_if.sink     pix_i,
  bvc_res_if.source   res_o
);

  cfg_t     cfg_q;
  logic     push, push_ok, pop, nonempty;
  q_entry_t wentry, head;

  // configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.underlay <= 1'b0;
      cfg_q.vp_x     <= '0;
      cfg_q.vp_y     <= '0;
      cfg_q.vp_w     <= DimW'(256);
      cfg_q.vp_h     <= DimW'(240);
      cfg_q.src_w    <= DimW'(256);
      cfg_q.src_h    <= DimW'(240);
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_UNDERLAY: cfg_q.underlay <= cfg_i.data[0];
        REG_VP_X:     cfg_q.vp_x     <= cfg_i.data;
        REG_VP_Y:     cfg_q.vp_y     <= cfg_i.data;
        REG_VP_W:     cfg_q.vp_w     <= cfg_i.data;
        REG_VP_H:     cfg_q.vp_h     <= cfg_i.data;
        REG_SRC_W:    cfg_q.src_w    <= cfg_i.data;
        REG_SRC_H:    cfg_q.src_h    <= cfg_i.data;
        default: ;
      endcase
    end
  end

  bvc_front #(.MAX_DIMENSION(MAX_DIMENSION)) u_front (
    .clk_i, .rst_ni,
    .cfg_i      (cfg_q),
    .in_valid_i (pix_i.valid),
    .in_ready_o (pix_i.ready),
    .canvas_x_i (pix_i.canvas_x),
    .canvas_y_i (pix_i.canvas_y),
    .border_i   (pix_i.border_pixel),
    .game_i     (pix_i.game_pixel),
    .push_o     (push),
    .push_ok_i  (push_ok),
    .entry_o    (wentry)
  );

  bvc_queue u_queue (
    .clk_i, .rst_ni,
    .push_i     (push),
    .wdata_i    (wentry),
    .push_ok_o  (push_ok),
    .pop_i      (pop),
    .nonempty_o (nonempty),
    .rdata_o    (head)
  );

  bvc_back u_back (
    .clk_i, .rst_ni,
    .nonempty_i    (nonempty),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (res_o.valid),
    .out_ready_i   (res_o.ready),
    .out_pixel_o   (res_o.out_pixel),
    .in_viewport_o (res_o.in_viewport),
    .source_x_o    (res_o.source_x),
    .source_y_o    (res_o.source_y)
  );

endmodule

`default_nettype wire

/* design/bvc_checker.sv */
// ----------------------------------------------------------------------------
// bvc_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bvc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        res_valid,
  input wire logic        res_ready,
  input wire logic [31:0] res_pixel,
  input wire logic        res_inside,
  input wire logic [11:0] res_sx,
  input wire logic [11:0] res_sy
);

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid && $stable(res_pixel))
    else $error("result dropped or changed while stalled");

  // outside the viewport the source position reads zero
  a_outside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_inside |-> res_sx == 12'd0 && res_sy == 12'd0)
    else $error("nonzero source position outside viewport");

  // pipeline is empty coming out of reset
  a_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !res_valid)
    else $error("result valid right after reset");

  // nothing can reach the output in the first cycle after reset
  a_fill: assert property (@(posedge clk_i)
    $past(!rst_ni) && rst_ni |=> !res_valid)
    else $error("result appeared before pipeline could fill");

endmodule

bind border_viewport_compositor bvc_checker u_bvc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .res_valid  (res_o.valid),
  .res_ready  (res_o.ready),
  .res_pixel  (res_o.out_pixel),
  .res_inside (res_o.in_viewport),
  .res_sx     (res_o.source_x),
  .res_sy     (res_o.source_y)
);

`default_nettype wire

/* tb/sv/border_viewport_compositor_tb.sv */
// ----------------------------------------------------------------------------
// border_viewport_compositor_tb
// Self-checking bench: drives canvas pixels and register writes, predicts each
// composited beat and compares it field by field, in order, with the output.
// ----------------------------------------------------------------------------
`default_nettype none

module border_viewport_compositor_tb import bvc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxDim   = 4096;
  localparam int Watchdog = 20000;

  typedef struct packed {
    logic [11:0] cx;
    logic [11:0] cy;
    logic [31:0] border;
    logic [31:0] game;
  } pix_t;

  typedef struct packed {
    logic [31:0] pix;
    logic        in_vp;
    logic [11:0] sx;
    logic [11:0] sy;
  } res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  bvc_cfg_if cfg_if ();
  bvc_pix_if pix_if ();
  bvc_res_if res_if ();

  border_viewport_compositor #(.MAX_DIMENSION(MaxDim)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_if),
    .pix_i (pix_if),
    .res_o (res_if)
  );

  always #5 clk_i = ~clk_i;

  // Shadow registers for prediction
  logic        m_underlay;
  logic [12:0] m_vpx, m_vpy, m_vpw, m_vph, m_srcw, m_srch;

  pix_t pending_px[$];
  res_t expected_res[$];
  int   send_idle_pct, recv_stall_pct;
  int   errors, idle_cycles;
  bit   cfg_busy;
  bit   pix_acc = 1'b0;   // pixel beat taken at the last rising edge
  bit   cfg_acc = 1'b0;   // config beat taken at the last rising edge
  logic [2:0]  cfg_idx_q;
  logic [12:0] cfg_data_q;

  function automatic logic [12:0] clamp_dim(logic [12:0] v);
    return (v > MaxDim) ? 13'(MaxDim) : v;
  endfunction

  // One axis of the viewport test and nearest-neighbor mapping
  function automatic logic axis_hit(logic [11:0] c, logic [12:0] org, logic [12:0] vsz,
                                    logic [12:0] ssz, output logic [11:0] src);
    int off;
    int unsigned vs, ss;
    off = int'(c) - int'($signed(org));
    vs = clamp_dim(vsz);
    ss = clamp_dim(ssz);
    src = '0;
    if (vs == 0 || off < 0 || off >= int'(vs)) return 1'b0;
    src = 12'((int'(off) * ss) / vs);
    return 1'b1;
  endfunction

  function automatic logic [31:0] blend_over(logic [31:0] under, logic [31:0] over);
    int unsigned a, inv, r, g, b, oa;
    a = over[31:24];
    if (a == 255) return over;
    if (a == 0) return under;
    inv = 255 - a;
    r = (over[23:16] * a + under[23:16] * inv) / 255;
    g = (over[15:8] * a + under[15:8] * inv) / 255;
    b = (over[7:0] * a + under[7:0] * inv) / 255;
    oa = a + (under[31:24] * inv) / 255;
    return {oa[7:0], r[7:0], g[7:0], b[7:0]};
  endfunction

  function automatic res_t composite(pix_t p);
    res_t r;
    logic hx, hy;
    hx = axis_hit(p.cx, m_vpx, m_vpw, m_srcw, r.sx);
    hy = axis_hit(p.cy, m_vpy, m_vph, m_srch, r.sy);
    r.in_vp = hx & hy;
    if (!r.in_vp) begin
      r.sx = '0;
      r.sy = '0;
    end
    if (m_underlay) r.pix = r.in_vp ? p.game : p.border;
    else r.pix = blend_over(r.in_vp ? p.game : 32'd0, p.border);
    return r;
  endfunction

  // Driver: pops a pending pixel when the channel is free, sets result ready, drives config writes
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!pix_if.valid || pix_acc) begin
        if (pending_px.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          pix_t p;
          p = pending_px.pop_front();
          pix_if.canvas_x <= p.cx;
          pix_if.canvas_y <= p.cy;
          pix_if.border_pixel <= p.border;
          pix_if.game_pixel <= p.game;
          pix_if.valid <= 1'b1;
        end else begin
          pix_if.valid <= 1'b0;
        end
      end
      res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      if (cfg_acc) cfg_if.valid <= 1'b0;
      else if (cfg_busy && !cfg_if.valid) begin
        cfg_if.index <= cfg_idx_q;
        cfg_if.data <= cfg_data_q;
        cfg_if.valid <= 1'b1;
      end
    end
  end

  // Monitor: predicts on input beats, checks on result beats, tracks config writes
  always @(posedge clk_i) begin
    if (rst_ni) begin
      pix_acc = pix_if.valid && pix_if.ready;
      cfg_acc = cfg_if.valid && cfg_if.ready;
      if (pix_if.valid && pix_if.ready)
        expected_res.push_back(composite({pix_if.canvas_x, pix_if.canvas_y,
                                          pix_if.border_pixel, pix_if.game_pixel}));
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          REG_UNDERLAY: m_underlay = cfg_if.data[0];
          REG_VP_X:     m_vpx = cfg_if.data;
          REG_VP_Y:     m_vpy = cfg_if.data;
          REG_VP_W:     m_vpw = cfg_if.data;
          REG_VP_H:     m_vph = cfg_if.data;
          REG_SRC_W:    m_srcw = cfg_if.data;
          REG_SRC_H:    m_srch = cfg_if.data;
          default: ;
        endcase
        cfg_busy = 1'b0;
      end
      if (res_if.valid && res_if.ready) begin
        idle_cycles = 0;
        if (expected_res.size() == 0) begin
          errors++;
          if (errors <= 10) $display("Unexpected result beat: %h", res_if.out_pixel);
        end else begin
          res_t e;
          e = expected_res.pop_front();
          if (e.pix !== res_if.out_pixel || e.in_vp !== res_if.in_viewport ||
              e.sx !== res_if.source_x || e.sy !== res_if.source_y) begin
            errors++;
            if (errors <= 10)
              $display("Mismatch: exp pix=%h in=%b sx=%0d sy=%0d got pix=%h in=%b sx=%0d sy=%0d",
                       e.pix, e.in_vp, e.sx, e.sy, res_if.out_pixel, res_if.in_viewport,
                       res_if.source_x, res_if.source_y);
          end
        end
      end else if (pix_if.valid && pix_if.ready) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= Watchdog) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [12:0] val);
    cfg_idx_q = idx;
    cfg_data_q = val;
    cfg_busy = 1'b1;
    while (cfg_busy) @(posedge clk_i);
  endtask

  task automatic drain();
    while (pending_px.size() > 0 || pix_if.valid || expected_res.size() > 0)
      @(posedge clk_i);
    repeat (25) @(posedge clk_i);
  endtask

  task automatic set_view(logic um, int vx, int vy, int vw, int vh, int sw, int sh);
    drain();
    write_reg(REG_UNDERLAY, {12'd0, um});
    write_reg(REG_VP_X, 13'(vx));
    write_reg(REG_VP_Y, 13'(vy));
    write_reg(REG_VP_W, 13'(vw));
    write_reg(REG_VP_H, 13'(vh));
    write_reg(REG_SRC_W, 13'(sw));
    write_reg(REG_SRC_H, 13'(sh));
  endtask

  // Pixels biased toward the viewport edges, random alpha extremes too
  function automatic pix_t rand_pixel();
    pix_t p;
    int vx, vy;
    vx = $signed(m_vpx);
    vy = $signed(m_vpy);
    p.cx = $urandom_range(3) == 0 ? 12'($urandom) : 12'(vx + $urandom_range(clamp_dim(m_vpw) + 2) - 1);
    p.cy = $urandom_range(3) == 0 ? 12'($urandom) : 12'(vy + $urandom_range(clamp_dim(m_vph) + 2) - 1);
    p.border = $urandom;
    case ($urandom_range(3))
      0: p.border[31:24] = 8'hFF;
      1: p.border[31:24] = 8'h00;
      default: ;
    endcase
    p.game = $urandom;
    return p;
  endfunction

  task automatic run_random(int n);
    repeat (n) pending_px.push_back(rand_pixel());
  endtask

  initial begin
    pix_if.valid = 1'b0;
    pix_if.canvas_x = '0;
    pix_if.canvas_y = '0;
    pix_if.border_pixel = '0;
    pix_if.game_pixel = '0;
    res_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    m_underlay = 1'b0;
    m_vpx = 0; m_vpy = 0; m_vpw = 256; m_vph = 240; m_srcw = 256; m_srch = 240;
    send_idle_pct = 0; recv_stall_pct = 0;
    errors = 0; idle_cycles = 0; cfg_busy = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // Directed: reset defaults, corners, alpha extremes
    pending_px.push_back({12'd0, 12'd0, 32'hFF123456, 32'hAABBCCDD});
    pending_px.push_back({12'd255, 12'd239, 32'h00FFFFFF, 32'h11223344});
    pending_px.push_back({12'd256, 12'd100, 32'h80FF00FF, 32'hFFFFFFFF});
    pending_px.push_back({12'd100, 12'd240, 32'h01000000, 32'hFFFFFFFF});
    pending_px.push_back({12'd4095, 12'd4095, 32'hFE808080, 32'h00000000});
    pending_px.push_back({12'd128, 12'd120, 32'h7F00FF00, 32'hFF0000FF});
    set_view(1'b1, -4096, -4096, 4096, 4096, 4096, 4096);
    pending_px.push_back({12'd0, 12'd0, 32'hFFFFFFFF, 32'h12345678});
    pending_px.push_back({12'd4095, 12'd4095, 32'h00000000, 32'h87654321});
    set_view(1'b1, 4095, 4095, 1, 1, 1, 1);
    pending_px.push_back({12'd4095, 12'd4095, 32'hFFFFFFFF, 32'hCAFEF00D});
    pending_px.push_back({12'd4094, 12'd4095, 32'h55AA55AA, 32'hCAFEF00D});
    // Zero and oversized dimensions
    set_view(1'b0, 0, 0, 0, 8191, 8191, 0);
    pending_px.push_back({12'd0, 12'd0, 32'h40102030, 32'hFFFFFFFF});
    set_view(1'b0, 10, 20, 8191, 50, 0, 8191);
    pending_px.push_back({12'd4000, 12'd30, 32'h40102030, 32'hFFFFFFFF});
    pending_px.push_back({12'd10, 12'd69, 32'hC0102030, 32'h80FFFFFF});

    // Random phases across several settings and idling mixes
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      set_view(ph[0], int'($urandom_range(8191)) - 4096 >>> (ph < 4 ? 4 : 0),
               $urandom_range(600) - 300, $urandom_range(1, ph == 7 ? 4096 : 512),
               $urandom_range(1, 400), $urandom_range(1, ph == 6 ? 4096 : 512),
               $urandom_range(1, 400));
      run_random(90);
    end
    drain();
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
design/bvc_pkg.sv
design/bvc_if.sv
design/bvc_front.sv
design/bvc_queue.sv
design/bvc_back.sv
design/border_viewport_compositor.sv
design/bvc_checker.sv
tb/sv/border_viewport_compositor_tb.sv
